/* src/sequential_readahead_prefetcher_unit_macros.svh */
// Assertion macros for the sequential read-ahead prefetcher.
`ifndef SEQUENTIAL_READAHEAD_PREFETCHER_UNIT_MACROS_SVH
`define SEQUENTIAL_READAHEAD_PREFETCHER_UNIT_MACROS_SVH
`ifndef SYNTH
`define SRP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SRP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SRP_ASSERT(label, clk, rst_n, prop, msg)
`define SRP_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

/* src/srp_pkg.sv */
// Types and constants shared by the sequential read-ahead prefetcher.
package srp_pkg;

    localparam logic [1:0] ACT_OPEN  = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_CLOSE = 2'd2;

    localparam int         RESULT_LIMIT  = 32;
    localparam int         CNT_W         = 6;
    localparam logic [7:0] RUN_THRESHOLD = 8'd2;
    localparam logic [7:0] RUN_MAX       = 8'd255;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  handle_slot;
        logic [47:0] read_offset;
        logic [47:0] new_end;
        logic [32:0] budget_bytes;
    } t_in_req;

    typedef struct packed {
        logic [27:0] prefetch_block;
        logic        last_of_run;
    } t_out_req;

    typedef struct packed {
        logic [27:0]      start_block;
        logic [CNT_W-1:0] count;
    } t_job;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    typedef enum logic {
        FR_IDLE,
        FR_LOOKUP
    } t_front_state;

    typedef enum logic {
        BK_IDLE,
        BK_EMIT
    } t_back_state;

endpackage

/* src/srp_front.sv */
// Front end: slot table lookup, run and window update, prefetch job issue.
module srp_front import srp_pkg::*; #(
    parameter int HANDLE_SLOTS = 16,
    parameter int BLOCK_SHIFT  = 20,
    parameter int MAX_WINDOW   = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  t_in_req i_req,
    output logic    o_idle,
    output logic    o_push,
    output t_job    o_job
);

    localparam int SW = (HANDLE_SLOTS > 1) ? $clog2(HANDLE_SLOTS) : 1;
    localparam int WW = $clog2(MAX_WINDOW + 1);

    t_front_state r_state, n_state;

    logic [47:0]   r_end_mem [HANDLE_SLOTS];
    logic [7:0]    r_run_mem [HANDLE_SLOTS];
    logic [WW-1:0] r_win_mem [HANDLE_SLOTS];
    logic [HANDLE_SLOTS-1:0] r_valid;

    t_in_req       r_cmd;
    logic [SW-1:0] r_idx;
    logic          r_in_range;
    logic [47:0]   r_rd_end;
    logic [7:0]    r_rd_run;
    logic [WW-1:0] r_rd_win;

    logic [8:0]    w_slot_ext;
    logic [SW-1:0] w_idx;
    logic          w_lookup;
    logic          w_hit;
    logic [7:0]    w_run_n;
    logic [WW:0]   w_win_dbl;
    logic [WW-1:0] w_win_n;
    logic          w_is_read;
    logic          w_is_open;
    logic [7:0]    w_win8;
    logic [7:0]    w_lim8;
    logic [32:0]   w_cap;
    logic [32:0]   w_cap1;
    logic [47:0]   w_end_blk;

    assign w_slot_ext = {5'd0, i_req.handle_slot};
    assign w_idx      = w_slot_ext[SW-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            FR_IDLE: begin
                if (i_accept) begin
                    n_state = FR_LOOKUP;
                end
            end
            FR_LOOKUP: n_state = FR_IDLE;
            default:   n_state = FR_IDLE;
        endcase
    end

    always_comb begin
        o_idle   = 1'b0;
        w_lookup = 1'b0;
        case (r_state)
            FR_IDLE:   o_idle   = 1'b1;
            FR_LOOKUP: w_lookup = 1'b1;
            default:   o_idle   = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        w_hit     = (r_cmd.read_offset == r_rd_end);
        w_win_dbl = {1'b0, r_rd_win} << 1;
        if (!w_hit) begin
            w_run_n = 8'd0;
            w_win_n = '0;
        end else begin
            w_run_n = (r_rd_run == RUN_MAX) ? r_rd_run : r_rd_run + 8'd1;
            if (r_rd_win == '0) begin
                w_win_n = WW'(1);
            end else if (w_win_dbl > (WW+1)'(MAX_WINDOW)) begin
                w_win_n = WW'(MAX_WINDOW);
            end else begin
                w_win_n = w_win_dbl[WW-1:0];
            end
        end
        w_is_read = w_lookup && r_in_range && (r_cmd.action == ACT_READ) &&
                    (r_cmd.budget_bytes != 33'd0) && r_valid[r_idx];
        w_is_open = w_lookup && r_in_range && (r_cmd.action == ACT_OPEN);
        w_win8    = 8'(w_win_n);
        w_lim8    = (w_win8 > 8'(RESULT_LIMIT)) ? 8'(RESULT_LIMIT) : w_win8;
        w_cap     = r_cmd.budget_bytes >> (BLOCK_SHIFT + 1);
        w_cap1    = (w_cap == 33'd0) ? 33'd1 : w_cap;
        w_end_blk = r_cmd.new_end >> BLOCK_SHIFT;
        o_push    = w_is_read && (w_run_n >= RUN_THRESHOLD) && (w_win_n != '0);
        o_job.start_block = w_end_blk[27:0];
        o_job.count = (w_cap1 < {25'd0, w_lim8}) ? w_cap1[CNT_W-1:0] : w_lim8[CNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_cmd      <= i_req;
            r_idx      <= w_idx;
            r_in_range <= (w_slot_ext < 9'(HANDLE_SLOTS));
            r_rd_end   <= r_end_mem[w_idx];
            r_rd_run   <= r_run_mem[w_idx];
            r_rd_win   <= r_win_mem[w_idx];
        end
        if (w_is_open) begin
            r_end_mem[r_idx] <= 48'd0;
            r_run_mem[r_idx] <= 8'd0;
            r_win_mem[r_idx] <= '0;
        end else if (w_is_read) begin
            r_end_mem[r_idx] <= r_cmd.new_end;
            r_run_mem[r_idx] <= w_run_n;
            r_win_mem[r_idx] <= w_win_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_lookup && r_in_range) begin
            if (r_cmd.action == ACT_OPEN) begin
                r_valid[r_idx] <= 1'b1;
            end else if (r_cmd.action == ACT_CLOSE) begin
                r_valid[r_idx] <= 1'b0;
            end
        end
    end

endmodule

/* src/srp_queue.sv */
// Short job queue between the front end and the prefetch issue stage.
module srp_queue import srp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_job      i_job,
    input  logic      i_pop,
    output t_job      o_job,
    output t_q_status o_status
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_job              r_slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [CW-1:0]     r_count;

    assign o_job           = r_slots[r_rd_ptr];
    assign o_status.empty  = (r_count == '0);
    assign o_status.full   = (r_count == CW'(QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

/* src/srp_back.sv */
// Back end: issue one prefetch block index per cycle for each queued job.
module srp_back import srp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job      i_job,
    input  t_q_status i_status,
    output logic      o_pop,
    output logic      o_strobe,
    output t_out_req  o_res
);

    t_back_state      r_state, n_state;
    logic [27:0]      r_block;
    logic [CNT_W-1:0] r_left;
    logic             w_last;

    assign w_last = (r_left == CNT_W'(1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (!i_status.empty) begin
                    n_state = BK_EMIT;
                end
            end
            BK_EMIT: begin
                if (w_last) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop    = 1'b0;
        o_strobe = 1'b0;
        o_res.prefetch_block = r_block;
        o_res.last_of_run    = w_last;
        case (r_state)
            BK_IDLE: o_pop    = !i_status.empty;
            BK_EMIT: o_strobe = 1'b1;
            default: o_pop    = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_block <= i_job.start_block;
            r_left  <= i_job.count;
        end else if (o_strobe) begin
            r_block <= r_block + 28'd1;
            r_left  <= r_left - CNT_W'(1);
        end
    end

endmodule

/* src/sequential_readahead_prefetcher_unit.sv */
// Top level of the sequential read-ahead prefetcher.
//
// Requests enter on i_req when start is high and busy is low: open, read
// completed or close for one handle slot. A read that continues a slot's
// run from its second sequential step on yields a burst of prefetch block
// indices on o_res, one per cycle with o_strobe high, the final one of the
// burst marked by last_of_run. The receiver takes every strobe; there is
// no back-pressure on the result side.
// Each request holds busy while the slot table is read and updated in the
// lookup state, so a new request is not taken before the last is through.
// The job is pushed in the same cycle as the slot update; the back end pops
// it from the queue when idle and then emits its burst of 1 to 32 indices,
// returning to idle between bursts. A two-entry job queue decouples the
// table update from the index issue; busy also stays high while that queue
// is full.
// Synchronous reset invalidates all slots and empties the queue; the slot
// contents need no clearing since a slot is only read after an open.
module sequential_readahead_prefetcher_unit import srp_pkg::*; #(
    parameter int HANDLE_SLOTS = 16,
    parameter int BLOCK_SHIFT  = 20,
    parameter int MAX_WINDOW   = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_in_req  i_req,
    output logic     busy,
    output logic     o_strobe,
    output t_out_req o_res
);

    `include "sequential_readahead_prefetcher_unit_macros.svh"

    logic      w_accept;
    logic      w_front_idle;
    logic      w_push;
    logic      w_pop;
    t_job      w_job_in;
    t_job      w_job_out;
    t_q_status w_q_status;

    assign busy     = !w_front_idle || w_q_status.full;
    assign w_accept = start && !busy;

    srp_front #(
        .HANDLE_SLOTS(HANDLE_SLOTS),
        .BLOCK_SHIFT (BLOCK_SHIFT),
        .MAX_WINDOW  (MAX_WINDOW)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(w_accept),
        .i_req   (i_req),
        .o_idle  (w_front_idle),
        .o_push  (w_push),
        .o_job   (w_job_in)
    );

    srp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_job   (w_job_out),
        .o_status(w_q_status)
    );

    srp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (w_job_out),
        .i_status(w_q_status),
        .o_pop   (w_pop),
        .o_strobe(o_strobe),
        .o_res   (o_res)
    );

    `SRP_ASSERT(a_accept_then_busy, i_clk, i_rst_n, w_accept |=> busy, "busy low after request")
    `SRP_ASSERT(a_no_push_full, i_clk, i_rst_n, !(w_push && w_q_status.full), "push into full queue")
    `SRP_ASSERT(a_gap_after_last, i_clk, i_rst_n, (o_strobe && o_res.last_of_run) |=> !o_strobe, "strobe right after last")
    `SRP_ASSERT(a_pop_not_empty, i_clk, i_rst_n, !(w_pop && w_q_status.empty), "pop from empty queue")

endmodule
